### sv/tbc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbc_pkg
// Shared types and constants of the trim batch coalescer.
// ----------------------------------------------------------------------------
package tbc_pkg;

  localparam int unsigned BatchDepth = 64;
  localparam int unsigned IdxW       = (BatchDepth > 1) ? $clog2(BatchDepth) : 1;
  localparam int unsigned CntW       = $clog2(BatchDepth + 1);
  localparam int unsigned AddrW      = 48;
  localparam int unsigned OffW       = 32;
  localparam int unsigned LenW       = 34;
  localparam int unsigned LimitW     = 7;
  localparam int unsigned SectW      = 5;
  localparam int unsigned PaddrW     = 3;

  localparam logic [LimitW-1:0] LimitReset  = 7'd64;
  localparam logic [SectW-1:0]  SectorReset = 5'd9;

  typedef enum logic [0:0] {
    RegBatchLimit = 1'b0,
    RegSectorLog2 = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [AddrW-1:0] key_location;
    logic [OffW-1:0]  data_offset;
    logic [OffW-1:0]  value_length;
  } in_item_t;

  typedef struct packed {
    logic [AddrW-1:0] trim_address;
    logic [LenW-1:0]  trim_length;
    logic             batch_last;
  } out_item_t;

  typedef struct packed {
    logic [AddrW-1:0] addr;
    logic [LenW-1:0]  len;
  } entry_t;

  typedef struct packed {
    logic [LimitW-1:0] batch_limit;
    logic [SectW-1:0]  sector_size_log2;
  } cfg_t;

  typedef enum logic [2:0] {
    StIdle,
    StScan,
    StAppend,
    StCheck,
    StDrain
  } state_e;

endpackage

### sv/tbc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tbc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                          rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/tbc_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbc_cfg
// APB register file: batch limit and sector size log2.
// ----------------------------------------------------------------------------
module tbc_cfg import tbc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  logic [LimitW-1:0] limit_q;
  logic [SectW-1:0]  sect_q;
  logic              wr_en;
  reg_idx_e          idx;

  assign idx   = reg_idx_e'(paddr[2]);
  assign wr_en = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitReset;
      sect_q  <= SectorReset;
    end else if (wr_en) begin
      case (idx)
        RegBatchLimit: limit_q <= pwdata[LimitW-1:0];
        RegSectorLog2: sect_q  <= pwdata[SectW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      RegBatchLimit: prdata = {{(32-LimitW){1'b0}}, limit_q};
      RegSectorLog2: prdata = {{(32-SectW){1'b0}}, sect_q};
      default:       prdata = '0;
    endcase
  end

  assign pready                 = 1'b1;
  assign cfg_o.batch_limit      = limit_q;
  assign cfg_o.sector_size_log2 = sect_q;

endmodule

### sv/tbc_trim_len.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbc_trim_len
// Two-stage trim length: offset plus length, rounded up to whole sectors,
// at least one sector.
// ----------------------------------------------------------------------------
module tbc_trim_len import tbc_pkg::*; (
  input  logic             clk_i,
  input  logic             load_i,
  input  logic [OffW-1:0]  off_i,
  input  logic [OffW-1:0]  len_i,
  input  logic [SectW-1:0] sector_log2_i,
  output logic [LenW-1:0]  length_o
);

  logic [OffW:0]   total_q;
  logic [LenW-1:0] len_q;
  logic [LenW-1:0] sector;
  logic [LenW-1:0] mask;
  logic [LenW-1:0] tot;
  logic [LenW-1:0] rounded;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      total_q <= {1'b0, off_i} + {1'b0, len_i};
    end
    len_q <= (tot <= sector) ? sector : rounded;
  end

  always_comb begin
    sector  = LenW'(1) << sector_log2_i;
    mask    = sector - LenW'(1);
    tot     = LenW'(total_q);
    rounded = (tot + mask) & ~mask;
  end

  assign length_o = len_q;

endmodule

### sv/trim_batch_coalescer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trim_batch_coalescer_core
// Collects trim items into a batch, drops duplicate key locations and
// drains the whole batch once it reaches the configured limit.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i/in_ready_o with in_item_i. Ready is high only
// while the sequencer is idle; one item is taken at a time.
// Output channel: out_valid_o/out_ready_i with out_item_o, one item per
// batch entry, batch_last set on the final one.
// Per input item: a duplicate scan over the n stored entries through the
// single RAM read port and one shared address comparator, stopping at the
// first match, then an append (skipped for a duplicate) and a limit check.
// A full batch of n entries drains at one item per cycle behind the
// registered RAM read while the receiver does not stall. A stall holds
// the output register and pauses the RAM reads; nothing is lost.
// The next input item is taken as soon as the last entry of a batch sits
// in the output register.
// Reset empties the batch and loads batch_limit = 64 and
// sector_size_log2 = 9; entry storage is not cleared.
// Registers over APB: 0x0 batch_limit, 0x4 sector_size_log2.
// ----------------------------------------------------------------------------
module trim_batch_coalescer_core import tbc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  in_item_t          in_item_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output out_item_t         out_item_o
);

  cfg_t              cfg;
  state_e            state_q, state_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [CntW-1:0]   idx_q, idx_d;
  logic [CntW-1:0]   ld_idx_q, ld_idx_d;
  logic              rdv_q, rdv_d;
  logic [AddrW-1:0]  key_q;
  logic              out_valid_q;
  out_item_t         out_q;
  logic [LenW-1:0]   entry_len;
  entry_t            wr_entry;
  entry_t            rd_entry;
  logic [$bits(entry_t)-1:0] rd_raw;
  logic              re;
  logic              we;
  logic              load;
  logic              accept;
  logic [LimitW-1:0] lim_raw;
  logic [CntW-1:0]   lim;
  logic              last_ld;

  tbc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  tbc_trim_len u_len (
    .clk_i         (clk_i),
    .load_i        (accept),
    .off_i         (in_item_i.data_offset),
    .len_i         (in_item_i.value_length),
    .sector_log2_i (cfg.sector_size_log2),
    .length_o      (entry_len)
  );

  assign wr_entry.addr = key_q;
  assign wr_entry.len  = entry_len;
  assign rd_entry      = entry_t'(rd_raw);

  tbc_ram #(
    .Width ($bits(entry_t)),
    .Depth (BatchDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (count_q[IdxW-1:0]),
    .wdata_i (wr_entry),
    .re_i    (re),
    .raddr_i (idx_q[IdxW-1:0]),
    .rdata_o (rd_raw)
  );

  always_comb begin
    lim_raw = cfg.batch_limit;
    if (lim_raw == '0) begin
      lim_raw = LimitW'(1);
    end
    if (lim_raw > LimitW'(BatchDepth)) begin
      lim_raw = LimitW'(BatchDepth);
    end
    lim = CntW'(lim_raw);
  end

  assign accept  = in_valid_i & in_ready_o;
  assign last_ld = (ld_idx_q == CntW'(count_q - CntW'(1)));

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    idx_d      = idx_q;
    ld_idx_d   = ld_idx_q;
    rdv_d      = rdv_q;
    re         = 1'b0;
    we         = 1'b0;
    load       = 1'b0;
    in_ready_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = StScan;
          idx_d   = '0;
          rdv_d   = 1'b0;
        end
      end
      StScan: begin
        if (rdv_q && (rd_entry.addr == key_q)) begin
          state_d = StCheck;
          rdv_d   = 1'b0;
        end else if (idx_q < count_q) begin
          re    = 1'b1;
          idx_d = idx_q + CntW'(1);
          rdv_d = 1'b1;
        end else begin
          state_d = StAppend;
          rdv_d   = 1'b0;
        end
      end
      StAppend: begin
        if (count_q < CntW'(BatchDepth)) begin
          we      = 1'b1;
          count_d = count_q + CntW'(1);
        end
        state_d = StCheck;
      end
      StCheck: begin
        if ((count_q >= lim) && (count_q != '0)) begin
          state_d  = StDrain;
          idx_d    = '0;
          ld_idx_d = '0;
          rdv_d    = 1'b0;
        end else begin
          state_d = StIdle;
        end
      end
      StDrain: begin
        load = rdv_q & (~out_valid_q | out_ready_i);
        re   = (idx_q < count_q) & (~rdv_q | load);
        if (re) begin
          idx_d = idx_q + CntW'(1);
        end
        rdv_d = re | (rdv_q & ~load);
        if (load) begin
          if (last_ld) begin
            count_d = '0;
            state_d = StIdle;
          end else begin
            ld_idx_d = ld_idx_q + CntW'(1);
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      idx_q       <= '0;
      ld_idx_q    <= '0;
      rdv_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      idx_q    <= idx_d;
      ld_idx_q <= ld_idx_d;
      rdv_q    <= rdv_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      key_q <= in_item_i.key_location;
    end
    if (load) begin
      out_q.trim_address <= rd_entry.addr;
      out_q.trim_length  <= rd_entry.len;
      out_q.batch_last   <= last_ld;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

### dv/tbc_trim_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbc_trim_checker
// Watches the APB port and both item channels of the trim batch coalescer.
// It keeps its own copy of the batch and the registers, predicts every
// drained trim item and compares each output item field by field.
// ----------------------------------------------------------------------------
module tbc_trim_checker import tbc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  input  logic [31:0]       prdata,
  input  logic              pready,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  in_item_t          in_item_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  out_item_t         out_item_i,
  output int unsigned       fail_cnt_o,
  output int unsigned       pending_o
);

  logic [LimitW-1:0] limit_q;
  logic [SectW-1:0]  log2_q;
  logic [AddrW-1:0]  batch_addr [BatchDepth];
  logic [LenW-1:0]   batch_len  [BatchDepth];
  int unsigned       batch_fill;
  out_item_t         trim_q [$];
  int unsigned       mismatches;

  function automatic logic [LenW-1:0] round_to_sectors(logic [SectW-1:0] lg,
                                                       logic [OffW-1:0] off,
                                                       logic [OffW-1:0] len);
    logic [63:0] sect;
    logic [63:0] total;
    logic [63:0] up;
    sect  = 64'd1 << lg;
    total = 64'(off) + 64'(len);
    up    = (total + sect - 64'd1) & ~(sect - 64'd1);
    if (total <= sect) up = sect;
    return up[LenW-1:0];
  endfunction

  function automatic int unsigned batch_target(logic [LimitW-1:0] lim);
    if (lim == 0) return 1;
    if (lim > BatchDepth) return BatchDepth;
    return int'(lim);
  endfunction

  task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("[%0t] mismatch %s: got %0h, expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic take_request(in_item_t it);
    bit          dup;
    int unsigned target;
    int unsigned i;
    out_item_t   o;
    dup    = 1'b0;
    target = batch_target(limit_q);
    for (i = 0; i < batch_fill; i++) begin
      if (batch_addr[i] == it.key_location) dup = 1'b1;
    end
    if (!dup && batch_fill < BatchDepth) begin
      batch_addr[batch_fill] = it.key_location;
      batch_len[batch_fill]  = round_to_sectors(log2_q, it.data_offset, it.value_length);
      batch_fill++;
    end
    if (batch_fill >= target && batch_fill > 0) begin
      for (i = 0; i < batch_fill; i++) begin
        o.trim_address = batch_addr[i];
        o.trim_length  = batch_len[i];
        o.batch_last   = (i + 1 == batch_fill);
        trim_q.push_back(o);
      end
      batch_fill = 0;
    end
  endtask

  task automatic check_trim(out_item_t got);
    out_item_t want;
    if (trim_q.size() == 0) begin
      flag_mismatch("unexpected trim item", 64'(got.trim_address), 64'd0);
    end else begin
      want = trim_q.pop_front();
      if (got.trim_address !== want.trim_address)
        flag_mismatch("trim_address", 64'(got.trim_address), 64'(want.trim_address));
      if (got.trim_length !== want.trim_length)
        flag_mismatch("trim_length", 64'(got.trim_length), 64'(want.trim_length));
      if (got.batch_last !== want.batch_last)
        flag_mismatch("batch_last", 64'(got.batch_last), 64'(want.batch_last));
    end
  endtask

  task automatic watch_apb();
    logic [31:0] want;
    case (reg_idx_e'(paddr[2]))
      RegBatchLimit: begin
        want = 32'(limit_q);
        if (pwrite) limit_q = pwdata[LimitW-1:0];
      end
      RegSectorLog2: begin
        want = 32'(log2_q);
        if (pwrite) log2_q = pwdata[SectW-1:0];
      end
      default: begin
        want = prdata;
      end
    endcase
    if (!pwrite && prdata !== want) flag_mismatch("register read", 64'(prdata), 64'(want));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q    = LimitReset;
      log2_q     = SectorReset;
      batch_fill = 0;
      trim_q.delete();
    end else begin
      if (psel && penable && pready) watch_apb();
      if (out_valid_i && out_ready_i) check_trim(out_item_i);
      if (in_valid_i && in_ready_i) take_request(in_item_i);
    end
    pending_o  <= trim_q.size();
    fail_cnt_o <= mismatches;
  end

endmodule

### dv/tb_trim_batch_coalescer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_trim_batch_coalescer_core
// Drives trim requests and register writes into the trim batch coalescer:
// a directed run over duplicates, rounding edges and limit changes, then
// random phases under several register settings and idle patterns,
// including one long receiver hold-off. A checker beside the block
// predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_trim_batch_coalescer_core;
  import tbc_pkg::*;

  localparam int unsigned HoldCycles    = 400;
  localparam int unsigned WatchdogLimit = 5000;
  localparam int unsigned SettleCycles  = 100;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              psel        = 1'b0;
  logic              penable     = 1'b0;
  logic              pwrite      = 1'b0;
  logic [PaddrW-1:0] paddr       = '0;
  logic [31:0]       pwdata      = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  in_item_t          in_item_i   = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  out_item_t         out_item_o;

  int unsigned       fail_cnt;
  int unsigned       pending;
  int unsigned       tx_idle_pct  = 0;
  int unsigned       rx_stall_pct = 0;
  bit                hold_req     = 1'b0;
  logic [SectW-1:0]  cur_log2     = SectorReset;
  logic [AddrW-1:0]  seen_keys [$];
  int unsigned       idle_cycles  = 0;

  trim_batch_coalescer_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  tbc_trim_checker i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_i  (out_item_o),
    .fail_cnt_o  (fail_cnt),
    .pending_o   (pending)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("watchdog: no item moved for %0d cycles", idle_cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver: random stalls, or one long hold-off on request
  initial begin : rx_drive
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end
      out_ready_i <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  function automatic in_item_t req(logic [AddrW-1:0] key, logic [OffW-1:0] off,
                                   logic [OffW-1:0] len);
    in_item_t it;
    it.key_location = key;
    it.data_offset  = off;
    it.value_length = len;
    return it;
  endfunction

  function automatic logic [OffW-1:0] random_span(logic [63:0] sect);
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      2:       return OffW'($urandom_range(4096));
      3:       return OffW'(sect * 64'($urandom_range(4))) + OffW'($urandom_range(2))
                      - OffW'(1);
      default: return OffW'($urandom());
    endcase
  endfunction

  task automatic random_request(output in_item_t it);
    int unsigned pick;
    logic [63:0] sect;
    sect = 64'd1 << cur_log2;
    pick = $urandom_range(99);
    if (pick < 35 && seen_keys.size() != 0) begin
      it.key_location = seen_keys[$urandom_range(seen_keys.size() - 1)];
    end else if (pick < 40) begin
      it.key_location = pick[0] ? '1 : '0;
    end else begin
      it.key_location = AddrW'({$urandom(), $urandom()});
    end
    it.data_offset  = random_span(sect);
    it.value_length = random_span(sect);
    seen_keys.push_back(it.key_location);
    if (seen_keys.size() > BatchDepth) void'(seen_keys.pop_front());
  endtask

  task automatic send_request(in_item_t it);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic apb_xfer(bit wr, reg_idx_e r, logic [31:0] v);
    paddr   <= {r, 2'b00};
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (wr && r == RegSectorLog2) cur_log2 = v[SectW-1:0];
    @(posedge clk_i);
  endtask

  // drop valid, wait for the last trim item, then let the block finish any scan
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic run_phase(logic [31:0] lim, logic [31:0] lg, int unsigned tx,
                           int unsigned rx, int unsigned n, bit squeeze);
    in_item_t it;
    settle();
    apb_xfer(1'b1, RegBatchLimit, lim);
    apb_xfer(1'b1, RegSectorLog2, lg);
    apb_xfer(1'b0, RegBatchLimit, '0);
    apb_xfer(1'b0, RegSectorLog2, '0);
    tx_idle_pct  = tx;
    rx_stall_pct = rx;
    seen_keys.delete();
    if (squeeze) hold_req = 1'b1;
    repeat (n) begin
      random_request(it);
      send_request(it);
    end
  endtask

  initial begin : stim
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    apb_xfer(1'b0, RegBatchLimit, '0);
    apb_xfer(1'b0, RegSectorLog2, '0);
    apb_xfer(1'b1, RegBatchLimit, 32'd3);
    apb_xfer(1'b1, RegSectorLog2, 32'd9);
    send_request(req('0, '0, '0));
    send_request(req('1, '1, '1));
    send_request(req('0, 32'd5, 32'd5));
    send_request(req(48'd5, 32'd512, 32'd0));

    // limit lowered below the current fill, with and without a duplicate
    settle();
    apb_xfer(1'b1, RegBatchLimit, 32'hFFFF_FFC0);
    send_request(req(48'd10, 32'd513, 32'd0));
    send_request(req(48'd11, 32'd0, 32'd1));
    send_request(req(48'd12, 32'd1000, 32'd24));
    settle();
    apb_xfer(1'b1, RegBatchLimit, 32'd2);
    send_request(req(48'd13, 32'd1, 32'd511));
    settle();
    apb_xfer(1'b1, RegBatchLimit, 32'd64);
    send_request(req(48'd20, 32'd100, 32'd100));
    send_request(req(48'd21, 32'd600, 32'd600));
    send_request(req(48'd22, 32'd0, 32'd2048));
    settle();
    apb_xfer(1'b1, RegBatchLimit, 32'd1);
    send_request(req(48'd21, 32'd7, 32'd7));

    // zero limit, sector sizes outside the usual range
    settle();
    apb_xfer(1'b1, RegBatchLimit, 32'h80);
    apb_xfer(1'b1, RegSectorLog2, 32'd0);
    send_request(req(48'd30, 32'd0, 32'd0));
    send_request(req(48'd31, 32'd3, 32'd4));
    settle();
    apb_xfer(1'b1, RegSectorLog2, 32'hFFFF_FFFF);
    send_request(req(48'd32, '1, '1));
    send_request(req(48'd33, 32'd1, 32'd0));
    settle();
    apb_xfer(1'b1, RegBatchLimit, 32'd1);
    apb_xfer(1'b1, RegSectorLog2, 32'd16);
    send_request(req(48'd34, 32'd65536, 32'd1));
    send_request(req(48'd35, 32'd32768, 32'd32768));

    run_phase(32'd4,   32'd9,  0,  0,  30,  1'b0);
    run_phase(32'd1,   32'd12, 70, 0,  25,  1'b0);
    run_phase(32'd7,   32'd16, 0,  70, 30,  1'b0);
    run_phase(32'd127, 32'd10, 27, 27, 110, 1'b0);
    run_phase(32'd3,   32'd9,  0,  0,  20,  1'b1);
    run_phase(32'd2,   32'd13, 27, 27, 25,  1'b0);
    run_phase(32'd5,   32'd0,  70, 70, 25,  1'b0);
    settle();

    if (fail_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
